FILE: sv/kchp_pkg.sv
// ----------------------------------------------------------------------------
// kchp_pkg: shared types and constants of the k-mer combine/partition unit
// Request payload structs, hash constants and named codes.
// ----------------------------------------------------------------------------
package kchp_pkg;

  // hash constants
  localparam logic [63:0] HASH_MUL   = 64'hc6a4_a793_5bd1_e995;
  localparam logic [63:0] HASH_SEED  = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned HASH_SHIFT = 47;
  localparam int unsigned HASH_LEN   = 8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_OWNERS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HITTER_ENABLE = 1'd1;
  localparam int unsigned CFG_DATA_W = 7;

  // request function codes
  localparam logic FUNC_KMER  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // packet kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_HEAVY  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] kmer;
    logic        last_of_buffer;
    logic [5:0]  drain_owner;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  dest_owner;
    logic        packet_kind;
    logic [63:0] out_kmer;
    logic [31:0] out_count;
    logic        packet_end;
  } out_item_t;

endpackage

FILE: sv/kmer_combine_hash_partition_unit.sv
// ----------------------------------------------------------------------------
// kmer_combine_hash_partition_unit: k-mer run combiner with owner packets
// Merges runs of equal k-mers and builds per-owner normal and heavy packets.
// ----------------------------------------------------------------------------
// One request is handled at a time. A k-mer that only opens or extends a run
// is absorbed in ST_IDLE. Each packet add (a closed run gives one or two) runs
// the iterative owner hash: four 64-bit multiplies on one 32x32 multiplier
// plus a remainder, then a fill-count read and the entry write. A full packet,
// or a drain, streams out entry by entry, each entry read from the packet
// memory and then emitted once the output register is free. After reset a
// clearing pass over all MAX_OWNERS fill counts zeroes them before the first
// request is taken; configuration writes are taken at any time.
module kmer_combine_hash_partition_unit #(
  parameter int unsigned MAX_OWNERS           = 64,
  parameter int unsigned HEAVY_PACKET_ENTRIES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  kchp_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output kchp_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kchp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kchp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int unsigned OW  = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
  localparam int unsigned NE  = 2 * HEAVY_PACKET_ENTRIES;
  localparam int unsigned NEW = $clog2(NE);
  localparam int unsigned HW  = (HEAVY_PACKET_ENTRIES > 1) ? $clog2(HEAVY_PACKET_ENTRIES) : 1;
  localparam int unsigned CW  = NEW + 1;
  localparam int unsigned OwnClamp = (MAX_OWNERS > 127) ? 127 : MAX_OWNERS;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_CLOSE = 9'b000000100,
    ST_HASH  = 9'b000001000,
    ST_FRD   = 9'b000010000,
    ST_FWAIT = 9'b000100000,
    ST_RD    = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_NEXT  = 9'b100000000
  } state_e;

  state_e st_q, st_d;

  // configuration
  logic [6:0] num_owners_q;
  logic       hitter_q;

  // run state
  logic [63:0] run_val_q, run_val_d;
  logic [31:0] run_cnt_q, run_cnt_d;
  logic        run_open_q, run_open_d;

  // current close: value and count to place
  logic [63:0] cl_val_q, cl_val_d;
  logic [31:0] cl_cnt_q, cl_cnt_d;
  logic        twice_q, twice_d;
  logic        heavy_q, heavy_d;
  logic        last_pend_q, last_pend_d;
  logic        drain_q, drain_d;
  logic        dh_pend_q, dh_pend_d;
  logic [OW-1:0] owner_q, owner_d;
  logic [HW-1:0] fh_q, fh_d;

  // flush sequencer
  logic          fl_kind_q, fl_kind_d;
  logic [CW-1:0] fl_cnt_q, fl_cnt_d;
  logic [CW-1:0] fl_idx_q, fl_idx_d;
  logic [OW-1:0] clr_q, clr_d;

  // output register
  logic                out_valid_q, out_valid_d;
  kchp_pkg::out_item_t out_q, out_d;

  // owner hash
  logic       hash_start;
  logic       hash_done;
  logic [6:0] hash_owner;
  logic [6:0] n_eff;

  // memories
  logic                 n_we, n_re, h_we, h_re, f_we, f_re;
  logic [OW+NEW-1:0]    n_waddr, n_raddr;
  logic [OW+HW-1:0]     h_waddr, h_raddr;
  logic [OW-1:0]        f_waddr;
  logic [63:0]          n_rdata;
  logic [95:0]          h_rdata;
  logic [NEW+HW-1:0]    f_wdata, f_rdata;
  logic [NEW-1:0]       fn_rd;
  logic [HW-1:0]        fh_rd;
  logic [CW-1:0]        fn_inc;
  logic [HW:0]          fh_inc;
  logic                 in_take, emit_last, out_load;

  assign fn_rd  = f_rdata[NEW+HW-1:HW];
  assign fh_rd  = f_rdata[HW-1:0];
  assign fn_inc = CW'(fn_rd) + CW'(1);
  assign fh_inc = (HW + 1)'(fh_rd) + (HW + 1)'(1);

  always_comb begin
    if (num_owners_q == 7'd0) begin
      n_eff = 7'd1;
    end else if (32'(num_owners_q) > OwnClamp) begin
      n_eff = 7'(OwnClamp);
    end else begin
      n_eff = num_owners_q;
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign emit_last   = (fl_idx_q + CW'(1)) == fl_cnt_q;

  kchp_owner u_owner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (cl_val_q),
    .n_i     (n_eff),
    .done_o  (hash_done),
    .owner_o (hash_owner)
  );

  kchp_ram #(.Width(64), .Depth(MAX_OWNERS << NEW)) u_normal_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (cl_val_q),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  kchp_ram #(.Width(96), .Depth(MAX_OWNERS << HW)) u_heavy_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i ({cl_cnt_q, cl_val_q}),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // fill counts: {normal fill, heavy fill} per owner
  kchp_ram #(.Width(NEW + HW), .Depth(MAX_OWNERS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (owner_q),
    .rdata_o (f_rdata)
  );

  assign n_waddr = {owner_q, fn_rd};
  assign h_waddr = {owner_q, fh_rd};
  assign n_raddr = {owner_q, fl_idx_q[NEW-1:0]};
  assign h_raddr = {owner_q, fl_idx_q[HW-1:0]};

  always_comb begin
    st_d        = st_q;
    run_val_d   = run_val_q;
    run_cnt_d   = run_cnt_q;
    run_open_d  = run_open_q;
    cl_val_d    = cl_val_q;
    cl_cnt_d    = cl_cnt_q;
    twice_d     = twice_q;
    heavy_d     = heavy_q;
    last_pend_d = last_pend_q;
    drain_d     = drain_q;
    dh_pend_d   = dh_pend_q;
    owner_d     = owner_q;
    fh_d        = fh_q;
    fl_kind_d   = fl_kind_q;
    fl_cnt_d    = fl_cnt_q;
    fl_idx_d    = fl_idx_q;
    clr_d       = clr_q;
    hash_start  = 1'b0;
    n_we        = 1'b0;
    n_re        = 1'b0;
    h_we        = 1'b0;
    h_re        = 1'b0;
    f_we        = 1'b0;
    f_re        = 1'b0;
    f_waddr     = owner_q;
    f_wdata     = '0;
    out_load    = 1'b0;
    out_d       = out_q;

    case (st_q)
      ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_q;
        clr_d   = clr_q + OW'(1);
        if (clr_q == OW'(MAX_OWNERS - 1)) begin
          st_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          twice_d     = 1'b0;
          last_pend_d = 1'b0;
          drain_d     = 1'b0;
          if (in_item_i.func == kchp_pkg::FUNC_DRAIN) begin
            if (32'(in_item_i.drain_owner) < MAX_OWNERS) begin
              owner_d = OW'(in_item_i.drain_owner);
              drain_d = 1'b1;
              st_d    = ST_FRD;
            end
          end else if (!hitter_q) begin
            // mode off: straight to a normal packet, run untouched
            cl_val_d = in_item_i.kmer;
            cl_cnt_d = 32'd1;
            st_d     = ST_CLOSE;
          end else if (run_open_q && in_item_i.kmer == run_val_q) begin
            if (in_item_i.last_of_buffer) begin
              cl_val_d   = run_val_q;
              cl_cnt_d   = (run_cnt_q == '1) ? run_cnt_q : run_cnt_q + 32'd1;
              run_val_d  = '0;
              run_cnt_d  = '0;
              run_open_d = 1'b0;
              st_d       = ST_CLOSE;
            end else if (run_cnt_q != '1) begin
              run_cnt_d = run_cnt_q + 32'd1;
            end
          end else if (run_open_q) begin
            // close the old run, then maybe the new one
            cl_val_d    = run_val_q;
            cl_cnt_d    = run_cnt_q;
            last_pend_d = in_item_i.last_of_buffer;
            run_val_d   = in_item_i.kmer;
            run_cnt_d   = 32'd1;
            run_open_d  = 1'b1;
            st_d        = ST_CLOSE;
          end else if (in_item_i.last_of_buffer) begin
            cl_val_d = in_item_i.kmer;
            cl_cnt_d = 32'd1;
            st_d     = ST_CLOSE;
          end else begin
            run_val_d  = in_item_i.kmer;
            run_cnt_d  = 32'd1;
            run_open_d = 1'b1;
          end
        end
      end

      ST_CLOSE: begin
        twice_d    = (cl_cnt_q == 32'd2);
        heavy_d    = (cl_cnt_q > 32'd2);
        hash_start = 1'b1;
        st_d       = ST_HASH;
      end

      ST_HASH: begin
        if (hash_done) begin
          owner_d = OW'(hash_owner);
          st_d    = ST_FRD;
        end
      end

      ST_FRD: begin
        f_re = 1'b1;
        st_d = ST_FWAIT;
      end

      ST_FWAIT: begin
        fh_d     = fh_rd;
        fl_idx_d = '0;
        f_we     = 1'b1;
        if (drain_q) begin
          f_wdata = '0;
          if (fn_rd != '0) begin
            fl_kind_d = kchp_pkg::KIND_NORMAL;
            fl_cnt_d  = CW'(fn_rd);
            dh_pend_d = 1'b1;
            st_d      = ST_RD;
          end else if (fh_rd != '0) begin
            fl_kind_d = kchp_pkg::KIND_HEAVY;
            fl_cnt_d  = CW'(fh_rd);
            dh_pend_d = 1'b0;
            st_d      = ST_RD;
          end else begin
            st_d = ST_IDLE;
          end
        end else if (heavy_q) begin
          h_we = 1'b1;
          if (fh_inc == (HW + 1)'(HEAVY_PACKET_ENTRIES)) begin
            f_wdata   = {fn_rd, HW'(0)};
            fl_kind_d = kchp_pkg::KIND_HEAVY;
            fl_cnt_d  = CW'(HEAVY_PACKET_ENTRIES);
            st_d      = ST_RD;
          end else begin
            f_wdata = {fn_rd, fh_inc[HW-1:0]};
            st_d    = ST_NEXT;
          end
        end else begin
          n_we = 1'b1;
          if (fn_inc == CW'(NE)) begin
            f_wdata   = {NEW'(0), fh_rd};
            fl_kind_d = kchp_pkg::KIND_NORMAL;
            fl_cnt_d  = CW'(NE);
            st_d      = ST_RD;
          end else begin
            f_wdata = {fn_inc[NEW-1:0], fh_rd};
            st_d    = ST_NEXT;
          end
        end
      end

      ST_RD: begin
        n_re = (fl_kind_q == kchp_pkg::KIND_NORMAL);
        h_re = (fl_kind_q == kchp_pkg::KIND_HEAVY);
        st_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load              = 1'b1;
          out_d.dest_owner      = 6'(owner_q);
          out_d.packet_kind     = fl_kind_q;
          out_d.packet_end      = emit_last;
          if (fl_kind_q == kchp_pkg::KIND_HEAVY) begin
            out_d.out_kmer  = h_rdata[63:0];
            out_d.out_count = h_rdata[95:64];
          end else begin
            out_d.out_kmer  = n_rdata;
            out_d.out_count = 32'd1;
          end
          fl_idx_d = fl_idx_q + CW'(1);
          if (!emit_last) begin
            st_d = ST_RD;
          end else if (dh_pend_q) begin
            // drain: heavy packet follows the normal one
            dh_pend_d = 1'b0;
            if (fh_q != '0) begin
              fl_kind_d = kchp_pkg::KIND_HEAVY;
              fl_cnt_d  = CW'(fh_q);
              fl_idx_d  = '0;
              st_d      = ST_RD;
            end else begin
              st_d = ST_NEXT;
            end
          end else begin
            st_d = ST_NEXT;
          end
        end
      end

      ST_NEXT: begin
        if (twice_q) begin
          // count two: second normal entry, same owner
          twice_d = 1'b0;
          st_d    = ST_FRD;
        end else if (last_pend_q) begin
          last_pend_d = 1'b0;
          cl_val_d    = run_val_q;
          cl_cnt_d    = run_cnt_q;
          run_val_d   = '0;
          run_cnt_d   = '0;
          run_open_d  = 1'b0;
          st_d        = ST_CLOSE;
        end else begin
          st_d = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_CLEAR;
      num_owners_q <= 7'd1;
      hitter_q     <= 1'b1;
      run_val_q    <= '0;
      run_cnt_q    <= '0;
      run_open_q   <= 1'b0;
      twice_q      <= 1'b0;
      heavy_q      <= 1'b0;
      last_pend_q  <= 1'b0;
      drain_q      <= 1'b0;
      dh_pend_q    <= 1'b0;
      clr_q        <= '0;
      fl_idx_q     <= '0;
      fl_cnt_q     <= '0;
      fl_kind_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      run_val_q   <= run_val_d;
      run_cnt_q   <= run_cnt_d;
      run_open_q  <= run_open_d;
      twice_q     <= twice_d;
      heavy_q     <= heavy_d;
      last_pend_q <= last_pend_d;
      drain_q     <= drain_d;
      dh_pend_q   <= dh_pend_d;
      clr_q       <= clr_d;
      fl_idx_q    <= fl_idx_d;
      fl_cnt_q    <= fl_cnt_d;
      fl_kind_q   <= fl_kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          kchp_pkg::CFG_NUM_OWNERS:    num_owners_q <= cfg_wdata_i[6:0];
          kchp_pkg::CFG_HITTER_ENABLE: hitter_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cl_val_q <= cl_val_d;
    cl_cnt_q <= cl_cnt_d;
    owner_q  <= owner_d;
    fh_q     <= fh_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a new request is only taken once all pending adds of the last one are done
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_ready_o |-> (!twice_q && !last_pend_q && !dh_pend_q))
    else $error("request taken with adds still pending");

  // flush index stays inside the packet being streamed
  a_flush_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q == ST_RD || st_q == ST_EMIT) |-> (fl_idx_q < fl_cnt_q))
    else $error("flush index past packet length");

  // hashed owner is always below the effective owner count
  a_owner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q == ST_HASH && hash_done) |-> (hash_owner < n_eff))
    else $error("owner out of range");

endmodule

FILE: sv/kchp_ram.sv
// ----------------------------------------------------------------------------
// kchp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module kchp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/kchp_owner.sv
// ----------------------------------------------------------------------------
// kchp_owner: iterative owner hash
// 64-bit mix on one shared 32x32 multiplier, then remainder by the owner
// count four bits per cycle.
// ----------------------------------------------------------------------------
module kchp_owner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  input  logic [6:0]  n_i,
  output logic        done_o,
  output logic [6:0]  owner_o
);

  localparam logic [63:0] HashInit =
      kchp_pkg::HASH_SEED ^ (kchp_pkg::HASH_MUL * 64'(kchp_pkg::HASH_LEN));
  localparam logic [31:0] MulLo = kchp_pkg::HASH_MUL[31:0];
  localparam logic [31:0] MulHi = kchp_pkg::HASH_MUL[63:32];

  logic        busy_q, busy_d;
  logic        mod_q, mod_d;
  logic [1:0]  op_q, op_d;
  logic [2:0]  ph_q, ph_d;
  logic [3:0]  mcnt_q, mcnt_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [6:0]  r_q, r_d;
  logic        done_q, done_d;
  logic [63:0] mixed;
  logic [7:0]  rem;

  always_comb begin
    if (op_q == 2'd1) begin
      mixed = HashInit ^ acc_q;
    end else begin
      mixed = acc_q ^ (acc_q >> kchp_pkg::HASH_SHIFT);
    end
  end

  // four restoring remainder steps on the top nibble; one spare bit so the
  // shifted partial remainder never overflows
  always_comb begin
    rem = {1'b0, r_q};
    for (int i = 0; i < 4; i++) begin
      rem = {rem[6:0], x_q[63-i]};
      if (rem >= {1'b0, n_i}) begin
        rem = rem - {1'b0, n_i};
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    mod_d  = mod_q;
    op_d   = op_q;
    ph_d   = ph_q;
    mcnt_d = mcnt_q;
    x_d    = x_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    r_d    = r_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      mod_d  = 1'b0;
      op_d   = 2'd0;
      ph_d   = 3'd0;
      x_d    = key_i;
    end else if (busy_q && mod_q) begin
      r_d    = rem[6:0];
      x_d    = {x_q[59:0], 4'b0};
      mcnt_d = mcnt_q + 4'd1;
      if (mcnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (busy_q) begin
      ph_d = ph_q + 3'd1;
      case (ph_q)
        3'd0: begin
          prod_d = {32'b0, x_q[31:0]} * {32'b0, MulLo};
        end
        3'd1: begin
          acc_d  = prod_q;
          prod_d = {32'b0, x_q[31:0]} * {32'b0, MulHi};
        end
        3'd2: begin
          acc_d  = acc_q + {prod_q[31:0], 32'b0};
          prod_d = {32'b0, x_q[63:32]} * {32'b0, MulLo};
        end
        3'd3: begin
          acc_d = acc_q + {prod_q[31:0], 32'b0};
        end
        default: begin
          ph_d = 3'd0;
          x_d  = mixed;
          if (op_q == 2'd3) begin
            mod_d  = 1'b1;
            r_d    = 7'd0;
            mcnt_d = 4'd0;
          end else begin
            op_d = op_q + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mod_q  <= 1'b0;
      done_q <= 1'b0;
      op_q   <= 2'd0;
      ph_q   <= 3'd0;
      mcnt_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      mod_q  <= mod_d;
      done_q <= done_d;
      op_q   <= op_d;
      ph_q   <= ph_d;
      mcnt_q <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    r_q    <= r_d;
  end

  assign done_o  = done_q;
  assign owner_o = r_q;

endmodule

FILE: bench/kchp_checker.sv
// ----------------------------------------------------------------------------
// kchp_checker: packet stream predictor and scoreboard
// Watches the request, configuration and packet channels. Keeps its own run
// state and per-owner packet stores, and compares each packet entry in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kchp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  kchp_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  kchp_pkg::out_item_t             out_item_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [kchp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kchp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int OWNERS      = 64;
  localparam int HEAVY_SLOTS = 16;
  localparam int NORMAL_SLOTS = 2 * HEAVY_SLOTS;
  localparam int RESULT_CAP  = 64;

  logic [6:0]  owners_cfg;
  logic        combine_on;
  logic [63:0] run_kmer;
  logic [31:0] run_len;
  logic        run_live;
  logic [63:0] normal_pkt [OWNERS][NORMAL_SLOTS];
  logic [63:0] heavy_pkt_kmer [OWNERS][HEAVY_SLOTS];
  logic [31:0] heavy_pkt_cnt [OWNERS][HEAVY_SLOTS];
  int          normal_fill [OWNERS];
  int          heavy_fill [OWNERS];
  int          step_results;
  kchp_pkg::out_item_t entries_due [$];

  function automatic logic [5:0] owner_of(logic [63:0] key);
    logic [63:0] h;
    logic [63:0] k;
    int unsigned n;
    n = owners_cfg;
    if (n == 0) n = 1;
    if (n > OWNERS) n = OWNERS;
    h = kchp_pkg::HASH_SEED ^ (64'(kchp_pkg::HASH_LEN) * kchp_pkg::HASH_MUL);
    k = key * kchp_pkg::HASH_MUL;
    k = k ^ (k >> kchp_pkg::HASH_SHIFT);
    k = k * kchp_pkg::HASH_MUL;
    h = h ^ k;
    h = h * kchp_pkg::HASH_MUL;
    h = h ^ (h >> kchp_pkg::HASH_SHIFT);
    h = h * kchp_pkg::HASH_MUL;
    h = h ^ (h >> kchp_pkg::HASH_SHIFT);
    return 6'(h % 64'(n));
  endfunction

  task automatic put_entry(logic [5:0] owner, logic kind, logic [63:0] kmer,
                           logic [31:0] cnt, logic last);
    kchp_pkg::out_item_t e;
    if (step_results < RESULT_CAP) begin
      e.dest_owner  = owner;
      e.packet_kind = kind;
      e.out_kmer    = kmer;
      e.out_count   = cnt;
      e.packet_end  = last;
      entries_due.push_back(e);
      step_results++;
    end
  endtask

  task automatic flush_normal(int o);
    for (int i = 0; i < normal_fill[o]; i++)
      put_entry(6'(o), kchp_pkg::KIND_NORMAL, normal_pkt[o][i], 32'd1,
                i + 1 == normal_fill[o]);
    normal_fill[o] = 0;
  endtask

  task automatic flush_heavy(int o);
    for (int i = 0; i < heavy_fill[o]; i++)
      put_entry(6'(o), kchp_pkg::KIND_HEAVY, heavy_pkt_kmer[o][i], heavy_pkt_cnt[o][i],
                i + 1 == heavy_fill[o]);
    heavy_fill[o] = 0;
  endtask

  task automatic add_normal(logic [63:0] kmer);
    int o;
    o = owner_of(kmer);
    normal_pkt[o][normal_fill[o]] = kmer;
    normal_fill[o]++;
    if (normal_fill[o] >= NORMAL_SLOTS) flush_normal(o);
  endtask

  task automatic add_heavy(logic [63:0] kmer, logic [31:0] cnt);
    int o;
    o = owner_of(kmer);
    heavy_pkt_kmer[o][heavy_fill[o]] = kmer;
    heavy_pkt_cnt[o][heavy_fill[o]]  = cnt;
    heavy_fill[o]++;
    if (heavy_fill[o] >= HEAVY_SLOTS) flush_heavy(o);
  endtask

  task automatic close_run();
    if (run_live) begin
      if (run_len <= 1) begin
        add_normal(run_kmer);
      end else if (run_len == 2) begin
        add_normal(run_kmer);
        add_normal(run_kmer);
      end else begin
        add_heavy(run_kmer, run_len);
      end
      run_live = 1'b0;
      run_kmer = '0;
      run_len  = '0;
    end
  endtask

  task automatic predict_request(kchp_pkg::in_item_t req);
    step_results = 0;
    if (req.func == kchp_pkg::FUNC_DRAIN) begin
      flush_normal(req.drain_owner);
      flush_heavy(req.drain_owner);
    end else if (!combine_on) begin
      add_normal(req.kmer);
    end else begin
      if (run_live && req.kmer == run_kmer) begin
        if (run_len != 32'hFFFF_FFFF) run_len++;
      end else begin
        close_run();
        run_kmer = req.kmer;
        run_len  = 32'd1;
        run_live = 1'b1;
      end
      if (req.last_of_buffer) close_run();
    end
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kchp_pkg::out_item_t want;
    if (!rst_ni) begin
      owners_cfg = 7'd1;
      combine_on = 1'b1;
      run_kmer   = '0;
      run_len    = '0;
      run_live   = 1'b0;
      for (int i = 0; i < OWNERS; i++) begin
        normal_fill[i] = 0;
        heavy_fill[i]  = 0;
      end
      entries_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // check the packet side first: an entry never comes from a same-edge request
      if (out_valid_i && out_ready_i) begin
        if (entries_due.size() == 0) begin
          report("unexpected entry, kmer", out_item_i.out_kmer, '0);
        end else begin
          want = entries_due.pop_front();
          if (out_item_i.dest_owner != want.dest_owner)
            report("dest_owner", 64'(out_item_i.dest_owner), 64'(want.dest_owner));
          if (out_item_i.packet_kind != want.packet_kind)
            report("packet_kind", 64'(out_item_i.packet_kind), 64'(want.packet_kind));
          if (out_item_i.out_kmer != want.out_kmer)
            report("out_kmer", out_item_i.out_kmer, want.out_kmer);
          if (out_item_i.out_count != want.out_count)
            report("out_count", 64'(out_item_i.out_count), 64'(want.out_count));
          if (out_item_i.packet_end != want.packet_end)
            report("packet_end", 64'(out_item_i.packet_end), 64'(want.packet_end));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == kchp_pkg::CFG_NUM_OWNERS) owners_cfg = cfg_wdata_i;
        else if (cfg_index_i == kchp_pkg::CFG_HITTER_ENABLE) combine_on = cfg_wdata_i[0];
      end
      if (in_valid_i && in_ready_i) predict_request(in_item_i);
      pending_o = entries_due.size();
    end
  end

endmodule

FILE: bench/kmer_combine_hash_partition_unit_test.sv
// ----------------------------------------------------------------------------
// kmer_combine_hash_partition_unit_test: top of the k-mer partition bench
// Drives directed and random k-mer/drain requests over several owner counts
// and combine modes, with random gaps and stalls; the checker scores output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmer_combine_hash_partition_unit_test;

  // generous: worst request (three hash adds + 64 stalled entries) times all requests
  localparam int CYCLE_LIMIT = 1500000;
  // a closed run can hash twice and stream a full packet
  localparam int QUIET_CYCLES = 300;

  localparam logic [6:0] PHASE_OWNERS [7] = '{7'd0, 7'd127, 7'd64, 7'd2, 7'd3, 7'd1, 7'd1};
  localparam logic       PHASE_MODE   [7] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam int         PHASE_ITEMS  [7] = '{40, 35, 35, 50, 40, 25, 35};

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  kchp_pkg::in_item_t              in_item;
  logic                            out_valid;
  logic                            out_ready;
  kchp_pkg::out_item_t             out_item;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [kchp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kchp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              fail_count;
  int                              pending;
  int                              cycles = 0;
  int                              stall_left;
  logic [63:0]                     kmer_pool [6];
  logic [63:0]                     last_kmer;

  kmer_combine_hash_partition_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  kchp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[kmer_combine_hash_partition_unit] ERROR");
      $finish;
    end
  end

  // packet side: a fresh random stall length is drawn after each accepted entry
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) stall_left = $urandom_range(0, 9);
      else if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  // one request; valid is only dropped when a gap is actually taken
  task automatic send(kchp_pkg::in_item_t req);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_kmer(logic [63:0] k, logic last);
    kchp_pkg::in_item_t req;
    req.func           = kchp_pkg::FUNC_KMER;
    req.kmer           = k;
    req.last_of_buffer = last;
    req.drain_owner    = 6'($urandom);
    send(req);
  endtask

  task automatic send_drain(logic [5:0] owner);
    kchp_pkg::in_item_t req;
    req.func           = kchp_pkg::FUNC_DRAIN;
    req.kmer           = {$urandom, $urandom};
    req.last_of_buffer = 1'($urandom);
    req.drain_owner    = owner;
    send(req);
  endtask

  // block must be quiet before a register write: all entries in, then a pause
  // since a request that yields nothing may still be hashing
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      repeat (QUIET_CYCLES) @(posedge clk);
    end while (pending != 0);
  endtask

  // dropping valid after the write keeps back-to-back writes apart
  task automatic write_reg(logic [kchp_pkg::CFG_IDX_W-1:0] idx,
                           logic [kchp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly runs over a small k-mer pool, with noise and stray drains
  task automatic send_random();
    logic [63:0] k;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_drain(6'($urandom));
    end else begin
      if (pick < 50) k = last_kmer;
      else if (pick < 88) k = kmer_pool[$urandom_range(0, 5)];
      else k = {$urandom, $urandom};
      last_kmer = k;
      send_kmer(k, $urandom_range(0, 99) < 15);
    end
  endtask

  initial begin
    int eff;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    last_kmer = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset config: one owner, combining on
    send_kmer(64'd0, 1'b1);                      // single: one normal entry
    send_kmer('1, 1'b0);
    send_kmer('1, 1'b1);                         // pair: two normal entries
    send_kmer(64'h0123_4567_89ab_cdef, 1'b0);
    send_kmer(64'h0123_4567_89ab_cdef, 1'b0);
    send_kmer(64'h0123_4567_89ab_cdef, 1'b0);    // run of three -> heavy
    send_kmer(64'h5555_aaaa_5555_aaaa, 1'b0);    // closes the heavy run
    send_drain(6'd5);                            // drain of an empty owner
    send_drain(6'd63);
    send_kmer(64'h5555_aaaa_5555_aaaa, 1'b1);
    send_drain(6'd0);                            // normal then heavy packet
    send_drain(6'd0);                            // now empty
    send_kmer(64'hdead_beef_0000_0001, 1'b0);    // run left open
    send_drain(6'd0);                            // drain leaves the run alone
    wait_quiet();
    write_reg(kchp_pkg::CFG_HITTER_ENABLE, 7'h7e); // mode off, upper data bits set
    send_kmer(64'hdead_beef_0000_0001, 1'b1);    // last ignored with mode off
    send_kmer(64'hdead_beef_0000_0001, 1'b0);
    send_kmer(64'h8000_0000_0000_0000, 1'b1);
    wait_quiet();
    write_reg(kchp_pkg::CFG_HITTER_ENABLE, 7'h01);
    send_kmer(64'hdead_beef_0000_0001, 1'b1);    // earlier run resumes, count 2
    send_drain(6'd0);

    // random phases over owner counts and modes, extremes included
    for (int p = 0; p < 7; p++) begin
      wait_quiet();
      write_reg(kchp_pkg::CFG_NUM_OWNERS, PHASE_OWNERS[p]);
      write_reg(kchp_pkg::CFG_HITTER_ENABLE, {6'($urandom), PHASE_MODE[p]});
      for (int i = 0; i < 6; i++) kmer_pool[i] = {$urandom, $urandom};
      for (int i = 0; i < PHASE_ITEMS[p]; i++) send_random();
      eff = (PHASE_OWNERS[p] == 0) ? 1 : (PHASE_OWNERS[p] > 64 ? 64 : PHASE_OWNERS[p]);
      if (eff <= 3 && p != 3) begin
        for (int o = 0; o < eff; o++) send_drain(6'(o));
      end else begin
        repeat (6) send_drain(6'($urandom_range(0, eff - 1)));
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("[kmer_combine_hash_partition_unit] OK");
    end else begin
      $display("[kmer_combine_hash_partition_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/kchp_pkg.sv
sv/kchp_ram.sv
sv/kchp_owner.sv
sv/kmer_combine_hash_partition_unit.sv
bench/kchp_checker.sv
bench/kmer_combine_hash_partition_unit_test.sv
